FILE: rtl/ppt_pkg.sv
// Package for the page permission table: field widths, operation and status
// codes, and the command/status structs between controller and datapath.
// No dependencies.
package ppt_pkg;

   localparam int ADDRESS_BITS       = 48;
   localparam int PAGE_OFFSET_BITS   = 12;
   localparam int SIZE_BITS          = ADDRESS_BITS + 1;
   localparam int FRAME_BITS         = ADDRESS_BITS - PAGE_OFFSET_BITS;
   // page count of a range: ceil(size / page), one bit more than size/page
   localparam int COUNT_BITS         = SIZE_BITS - PAGE_OFFSET_BITS + 1;
   localparam int OP_BITS            = 3;
   localparam int RIGHTS_BITS        = 3;
   localparam int STATUS_BITS        = 2;
   localparam int DEFAULT_PAGE_COUNT = 4096;

   localparam logic [OP_BITS-1:0] OP_MAP         = 3'd0;
   localparam logic [OP_BITS-1:0] OP_UNMAP       = 3'd1;
   localparam logic [OP_BITS-1:0] OP_CHECK       = 3'd2;
   localparam logic [OP_BITS-1:0] OP_QUERY_PROT  = 3'd3;
   localparam logic [OP_BITS-1:0] OP_SET_DIRTY   = 3'd4;
   localparam logic [OP_BITS-1:0] OP_CLEAR_DIRTY = 3'd5;
   localparam logic [OP_BITS-1:0] OP_QUERY_DIRTY = 3'd6;

   localparam logic [STATUS_BITS-1:0] ST_OK           = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_ZERO_SIZE    = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_OUT_OF_RANGE = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic ready;        // input channel may take a transaction
      logic decode;       // register range check, load walk counters
      logic walk;         // write one page of the range
      logic sweep;        // clearing pass: zero one entry of both stores
      logic prot_read;    // read protection of the addressed page
      logic dirty_read;   // read dirty bit of the frame
      logic dirty_write;  // set or clear dirty bit of the frame
      logic finish;       // load the result register
   } ppt_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic               req_valid;
      logic               rsp_free;
      logic               size_zero;
      logic               range_ok;
      logic               page_in;
      logic               frame_in;
      logic               walk_last;
      logic               sweep_last;
   } ppt_stat_type;

endpackage

FILE: rtl/ppt_channels.sv
// Valid/ready channel interfaces for the page permission table: request and
// response. Depends on ppt_pkg.
interface ppt_req_if import ppt_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OP_BITS-1:0]      operation;
   logic [ADDRESS_BITS-1:0] address;
   logic [SIZE_BITS-1:0]    size;
   logic [RIGHTS_BITS-1:0]  rights;
   logic [FRAME_BITS-1:0]   frame_number;

   modport source (output valid, operation, address, size, rights, frame_number,
                   input ready);
   modport sink   (input valid, operation, address, size, rights, frame_number,
                   output ready);
endinterface

interface ppt_rsp_if import ppt_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic                   allowed;
   logic [RIGHTS_BITS-1:0] protection;
   logic                   dirty;

   modport source (output valid, status, allowed, protection, dirty, input ready);
   modport sink   (input valid, status, allowed, protection, dirty, output ready);
endinterface

FILE: rtl/ppt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ppt_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ppt_ctrl.sv
// Controller state machine of the page permission table: clearing pass,
// decode, range walk and result hand-off. Depends on ppt_pkg.
module ppt_ctrl import ppt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  ppt_stat_type stat,
   output ppt_cmd_type  cmd
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_WALK   = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.ready = 1'b1;
            if (stat.req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = S_FINISH;
            case (stat.op)
               OP_MAP, OP_UNMAP: begin
                  if (!stat.size_zero && stat.range_ok) begin
                     state_in = S_WALK;
                  end
               end
               OP_CHECK, OP_QUERY_PROT: begin
                  cmd.prot_read = stat.page_in;
               end
               OP_SET_DIRTY, OP_CLEAR_DIRTY: begin
                  cmd.dirty_write = stat.frame_in;
               end
               OP_QUERY_DIRTY: begin
                  cmd.dirty_read = stat.frame_in;
               end
               default: begin
               end
            endcase
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (stat.walk_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // hand the result over and take the next transaction at once
            if (stat.rsp_free) begin
               cmd.finish = 1'b1;
               cmd.ready  = 1'b1;
               state_in   = stat.req_valid ? S_DECODE : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_sweep_alone: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep |-> !cmd.walk && !cmd.dirty_write && !cmd.ready)
      else $error("clearing pass overlaps other work");
   a_clear_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) && stat.sweep_last |=> (state_ff == S_IDLE))
      else $error("clearing pass did not end at last entry");
   a_walk_after_decode: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) && !$past(state_ff == S_WALK) |-> $past(state_ff == S_DECODE))
      else $error("range walk entered without decode");
`endif

endmodule

FILE: rtl/ppt_datapath.sv
// Datapath of the page permission table: captured request, range check,
// walk counters, the protection and dirty stores and the result register.
// Depends on ppt_pkg, ppt_channels and ppt_ram.
module ppt_datapath import ppt_pkg::*; #(
   parameter int PAGE_COUNT = DEFAULT_PAGE_COUNT
) (
   input  logic         clock,
   input  logic         reset,
   ppt_req_if.sink      req_chan,
   ppt_rsp_if.source    rsp_chan,
   input  ppt_cmd_type  cmd,
   output ppt_stat_type stat
);

   localparam int ENTRY_BITS = $clog2(PAGE_COUNT);
   localparam int CNT_BITS   = $clog2(PAGE_COUNT + 1);
   localparam int END_BITS   = COUNT_BITS + 1;
   localparam logic [FRAME_BITS-1:0] PAGE_LIMIT = FRAME_BITS'(PAGE_COUNT);
   localparam logic [END_BITS-1:0]   END_LIMIT  = END_BITS'(PAGE_COUNT);
   localparam logic [ENTRY_BITS-1:0] LAST_PAGE  = ENTRY_BITS'(PAGE_COUNT - 1);

   logic [OP_BITS-1:0]     op_ff, op_in;
   logic [FRAME_BITS-1:0]  first_ff, first_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   size_zero_ff, size_zero_in;
   logic [RIGHTS_BITS-1:0] rights_ff, rights_in;
   logic [FRAME_BITS-1:0]  frame_ff, frame_in;
   logic                   range_ok_ff, range_ok_in;
   logic [ENTRY_BITS-1:0]  cur_ff, cur_in;
   logic [CNT_BITS-1:0]    rem_ff, rem_in;
   logic [ENTRY_BITS-1:0]  sweep_ff, sweep_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic                   rsp_allowed_ff, rsp_allowed_in;
   logic [RIGHTS_BITS-1:0] rsp_prot_ff, rsp_prot_in;
   logic                   rsp_dirty_ff, rsp_dirty_in;

   logic                   accept;
   logic [END_BITS-1:0]    end_sum;
   logic                   range_ok;
   logic                   page_in;
   logic                   frame_ok;
   logic                   rsp_free;
   logic [RIGHTS_BITS-1:0] prot_rdata;
   logic                   dirty_rdata;
   logic                   prot_we;
   logic [ENTRY_BITS-1:0]  prot_waddr;
   logic [RIGHTS_BITS-1:0] prot_wdata;
   logic                   dirty_we;
   logic [ENTRY_BITS-1:0]  dirty_waddr;
   logic                   dirty_wdata;
   logic [RIGHTS_BITS-1:0] page_prot;
   logic [STATUS_BITS-1:0] res_status;
   logic                   res_allowed;
   logic [RIGHTS_BITS-1:0] res_prot;
   logic                   res_dirty;

   assign accept   = req_chan.valid && cmd.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   // range fits when first + count stays at or below the table end
   assign end_sum  = END_BITS'(first_ff) + END_BITS'(count_ff);
   assign range_ok = (end_sum <= END_LIMIT);
   assign page_in  = (first_ff < PAGE_LIMIT);
   assign frame_ok = (frame_ff < PAGE_LIMIT);

   assign stat.op         = op_ff;
   assign stat.req_valid  = req_chan.valid;
   assign stat.rsp_free   = rsp_free;
   assign stat.size_zero  = size_zero_ff;
   assign stat.range_ok   = range_ok;
   assign stat.page_in    = page_in;
   assign stat.frame_in   = frame_ok;
   assign stat.walk_last  = (rem_ff == CNT_BITS'(1));
   assign stat.sweep_last = (sweep_ff == LAST_PAGE);

   // store write ports: clearing pass has priority, it never overlaps work
   assign prot_we     = cmd.sweep || cmd.walk;
   assign prot_waddr  = cmd.sweep ? sweep_ff : cur_ff;
   assign prot_wdata  = (cmd.sweep || (op_ff != OP_MAP)) ? '0 : rights_ff;
   assign dirty_we    = cmd.sweep || cmd.dirty_write;
   assign dirty_waddr = cmd.sweep ? sweep_ff : frame_ff[ENTRY_BITS-1:0];
   assign dirty_wdata = !cmd.sweep && (op_ff == OP_SET_DIRTY);

   ppt_ram #(.WIDTH(RIGHTS_BITS), .DEPTH(PAGE_COUNT)) u_prot_ram (
      .clock   (clock),
      .wr_en   (prot_we),
      .wr_addr (prot_waddr),
      .wr_data (prot_wdata),
      .rd_en   (cmd.prot_read),
      .rd_addr (first_ff[ENTRY_BITS-1:0]),
      .rd_data (prot_rdata)
   );

   ppt_ram #(.WIDTH(1), .DEPTH(PAGE_COUNT)) u_dirty_ram (
      .clock   (clock),
      .wr_en   (dirty_we),
      .wr_addr (dirty_waddr),
      .wr_data (dirty_wdata),
      .rd_en   (cmd.dirty_read),
      .rd_addr (frame_ff[ENTRY_BITS-1:0]),
      .rd_data (dirty_rdata)
   );

   // result fields from captured request, flags and store read data
   always_comb begin
      res_status  = ST_OK;
      res_allowed = 1'b0;
      res_prot    = '0;
      res_dirty   = 1'b0;
      page_prot   = page_in ? prot_rdata : '0;
      case (op_ff)
         OP_MAP, OP_UNMAP: begin
            if (size_zero_ff) begin
               res_status = ST_ZERO_SIZE;
            end else if (!range_ok_ff) begin
               res_status = ST_OUT_OF_RANGE;
            end
         end
         OP_CHECK: begin
            res_status  = page_in ? ST_OK : ST_OUT_OF_RANGE;
            res_allowed = ((page_prot & rights_ff) == rights_ff);
         end
         OP_QUERY_PROT: begin
            res_status = page_in ? ST_OK : ST_OUT_OF_RANGE;
            res_prot   = page_prot;
         end
         OP_SET_DIRTY, OP_CLEAR_DIRTY: begin
            res_status = frame_ok ? ST_OK : ST_OUT_OF_RANGE;
         end
         OP_QUERY_DIRTY: begin
            res_status = frame_ok ? ST_OK : ST_OUT_OF_RANGE;
            res_dirty  = frame_ok && dirty_rdata;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      op_in          = op_ff;
      first_in       = first_ff;
      count_in       = count_ff;
      size_zero_in   = size_zero_ff;
      rights_in      = rights_ff;
      frame_in       = frame_ff;
      range_ok_in    = range_ok_ff;
      cur_in         = cur_ff;
      rem_in         = rem_ff;
      sweep_in       = sweep_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_allowed_in = rsp_allowed_ff;
      rsp_prot_in    = rsp_prot_ff;
      rsp_dirty_in   = rsp_dirty_ff;

      if (accept) begin
         op_in        = req_chan.operation;
         first_in     = req_chan.address[ADDRESS_BITS-1:PAGE_OFFSET_BITS];
         count_in     = COUNT_BITS'(req_chan.size[SIZE_BITS-1:PAGE_OFFSET_BITS])
                        + COUNT_BITS'(|req_chan.size[PAGE_OFFSET_BITS-1:0]);
         size_zero_in = (req_chan.size == '0);
         rights_in    = req_chan.rights;
         frame_in     = req_chan.frame_number;
      end
      if (cmd.decode) begin
         range_ok_in = range_ok;
         cur_in      = first_ff[ENTRY_BITS-1:0];
         rem_in      = count_ff[CNT_BITS-1:0];
      end
      if (cmd.walk) begin
         cur_in = cur_ff + ENTRY_BITS'(1);
         rem_in = rem_ff - CNT_BITS'(1);
      end
      if (cmd.sweep) begin
         sweep_in = sweep_ff + ENTRY_BITS'(1);
      end
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = res_status;
         rsp_allowed_in = res_allowed;
         rsp_prot_in    = res_prot;
         rsp_dirty_in   = res_dirty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      first_ff       <= first_in;
      count_ff       <= count_in;
      size_zero_ff   <= size_zero_in;
      rights_ff      <= rights_in;
      frame_ff       <= frame_in;
      range_ok_ff    <= range_ok_in;
      cur_ff         <= cur_in;
      rem_ff         <= rem_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_allowed_ff <= rsp_allowed_in;
      rsp_prot_ff    <= rsp_prot_in;
      rsp_dirty_ff   <= rsp_dirty_in;
   end

   assign req_chan.ready      = cmd.ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.allowed    = rsp_allowed_ff;
   assign rsp_chan.protection = rsp_prot_ff;
   assign rsp_chan.dirty      = rsp_dirty_ff;

`ifndef SYNTHESIS
   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> range_ok_ff && !size_zero_ff && (rem_ff != '0))
      else $error("page walk outside a checked range");
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> rsp_free)
      else $error("result register overwritten");
   a_walk_op: assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> (op_ff == OP_MAP) || (op_ff == OP_UNMAP))
      else $error("page walk for a single-page operation");
`endif

endmodule

FILE: rtl/page_permission_table.sv
// Top level of the page permission table; instantiates ppt_ctrl and
// ppt_datapath. Depends on ppt_pkg and ppt_channels.
//
// Per-page protection table: a read/write/execute triple and a dirty bit for
// each of PAGE_COUNT 4 KiB pages, held in two RAMs. After reset a clearing
// pass zeroes both RAMs, one entry per cycle, and req_chan.ready stays low
// until it is done. Each request transaction gives exactly one response
// transaction. Map/unmap write ceil(size/4096) pages from the page of the
// address; the range controller writes one page per cycle. A zero size
// (status 1) or a range that runs past the table end (status 2) changes
// nothing. Check, query protection and the dirty operations read or write
// one RAM entry; a page or frame beyond the table gives status 2, holds no
// rights and reads clean. The response sits in an output register: the next
// request is taken in the same cycle a response is loaded, as long as the
// previous response has been taken or is being taken.
module page_permission_table import ppt_pkg::*; #(
   parameter int PAGE_COUNT = DEFAULT_PAGE_COUNT
) (
   input  logic      clock,
   input  logic      reset,
   ppt_req_if.sink   req_chan,
   ppt_rsp_if.source rsp_chan
);

   ppt_cmd_type  cmd;
   ppt_stat_type stat;

   // sequencing: clear, decode, page walk, result hand-off
   ppt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   // request capture, range arithmetic, stores and response register
   ppt_datapath #(.PAGE_COUNT(PAGE_COUNT)) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .stat     (stat)
   );

endmodule
